// File: src/lpp_pkg.sv
// ----------------------------------------------------------------------------
// lpp_pkg
// Shared types and constants of the LL(1) predictive parse engine.
// ----------------------------------------------------------------------------
package lpp_pkg;

   localparam int TERMINALS_DEF    = 64;
   localparam int NONTERMINALS_DEF = 64;
   localparam int PRODUCTIONS_DEF  = 128;
   localparam int RHS_MAX_DEF      = 8;
   localparam int STACK_DEPTH_DEF  = 64;
   localparam int MAX_RESULTS      = 64;
   localparam int QUEUE_DEPTH      = 2;
   localparam int CSR_INDEX_W      = 1;
   localparam int CSR_DATA_W       = 7;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_START_SYMBOL  = 1'b0,
      CSR_NUM_TERMINALS = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      OP_TABLE = 2'd0,
      OP_RHS   = 2'd1,
      OP_TOKEN = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ACT_EXPAND    = 3'd0,
      ACT_MATCH     = 3'd1,
      ACT_ACCEPT    = 3'd2,
      ACT_NO_ENTRY  = 3'd3,
      ACT_AMBIGUOUS = 3'd4,
      ACT_MISMATCH  = 3'd5,
      ACT_INVALID   = 3'd6,
      ACT_OVERFLOW  = 3'd7
   } act_type;

   typedef struct packed {
      logic [1:0] operation;
      logic [5:0] cell_nonterminal;
      logic [6:0] cell_terminal;
      logic [1:0] cell_status;
      logic [6:0] production;
      logic [2:0] rhs_position;
      logic [6:0] rhs_symbol;
      logic [3:0] rhs_length;
      logic [6:0] token;
   } req_type;

   typedef struct packed {
      logic [2:0] action;
      logic [6:0] applied_production;
      logic       last;
   } rsp_type;

   // classified request as it sits in the queue
   typedef struct packed {
      op_type  kind;
      logic    ok;     // load in range, or token valid
      req_type req;
   } entry_type;

endpackage

// File: src/lpp_front.sv
// ----------------------------------------------------------------------------
// lpp_front
// Accepts requests, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module lpp_front #(
   parameter int TERMINALS    = lpp_pkg::TERMINALS_DEF,
   parameter int NONTERMINALS = lpp_pkg::NONTERMINALS_DEF,
   parameter int PRODUCTIONS  = lpp_pkg::PRODUCTIONS_DEF,
   parameter int RHS_MAX      = lpp_pkg::RHS_MAX_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  lpp_pkg::req_type   req_data,
   input  logic [6:0]         num_terminals,
   input  logic               busy,
   output logic               q_valid,
   output lpp_pkg::entry_type q_head,
   input  logic               q_pop
);
   import lpp_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_type        q_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   entry_type        ent;
   logic             push;

   always_comb begin
      ent.req  = req_data;
      ent.kind = op_type'(req_data.operation);
      case (ent.kind)
         OP_TABLE: ent.ok = ({1'b0, req_data.cell_nonterminal} < 7'(NONTERMINALS))
                            && ({1'b0, req_data.cell_terminal} < 8'(TERMINALS + 1));
         OP_RHS:   ent.ok = ({1'b0, req_data.production} < 8'(PRODUCTIONS))
                            && ({1'b0, req_data.rhs_position} < 4'(RHS_MAX));
         OP_TOKEN: ent.ok = (req_data.token == 7'(TERMINALS))
                            || ((req_data.token < num_terminals)
                                && (req_data.token < 7'(TERMINALS)));
         default:  ent.ok = 1'b0;
      endcase
   end

   assign req_stall = busy || (cnt_ff == CNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (cnt_ff != '0);
   assign q_head    = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !q_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!push && q_pop) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= ent;
      end
   end

endmodule

// File: src/lpp_engine.sv
// ----------------------------------------------------------------------------
// lpp_engine
// Back end: table and RHS stores, symbol stack and the parse sequencer.
// ----------------------------------------------------------------------------
module lpp_engine #(
   parameter int TERMINALS    = lpp_pkg::TERMINALS_DEF,
   parameter int NONTERMINALS = lpp_pkg::NONTERMINALS_DEF,
   parameter int PRODUCTIONS  = lpp_pkg::PRODUCTIONS_DEF,
   parameter int RHS_MAX      = lpp_pkg::RHS_MAX_DEF,
   parameter int STACK_DEPTH  = lpp_pkg::STACK_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  lpp_pkg::entry_type q_head,
   output logic               q_pop,
   output logic               busy,
   input  logic [5:0]         start_nt,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output lpp_pkg::rsp_type   rsp_data
);
   import lpp_pkg::*;

   localparam int COLUMNS   = TERMINALS + 1;
   localparam int TBL_DEPTH = NONTERMINALS * COLUMNS;
   localparam int TBL_AW    = $clog2(TBL_DEPTH);
   localparam int RHS_DEPTH = PRODUCTIONS * RHS_MAX;
   localparam int RHS_AW    = (RHS_DEPTH > 1) ? $clog2(RHS_DEPTH) : 1;
   localparam int PROD_AW   = (PRODUCTIONS > 1) ? $clog2(PRODUCTIONS) : 1;
   localparam int STK_AW    = $clog2(STACK_DEPTH);
   localparam int SP_W      = $clog2(STACK_DEPTH + 1);

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_CLEAR = 9'b000000010,
      S_TOP   = 9'b000000100,
      S_TOPW  = 9'b000001000,
      S_CELL  = 9'b000010000,
      S_LEN   = 9'b000100000,
      S_PUSHR = 9'b001000000,
      S_PUSHW = 9'b010000000,
      S_EMIT  = 9'b100000000
   } state_type;

   // stores
   logic [8:0] tbl_mem  [TBL_DEPTH];
   logic [6:0] sym_mem  [RHS_DEPTH];
   logic [3:0] len_mem  [PRODUCTIONS];
   logic [6:0] stk_mem  [STACK_DEPTH];

   logic [8:0] tbl_rd_ff;
   logic [6:0] sym_rd_ff;
   logic [3:0] len_rd_ff;
   logic [6:0] stk_rd_ff;

   logic              tbl_we, sym_we, stk_we;
   logic [TBL_AW-1:0] tbl_waddr, tbl_raddr;
   logic [8:0]        tbl_wdata;
   logic [RHS_AW-1:0] sym_waddr, sym_raddr;
   logic [PROD_AW-1:0] len_raddr;
   logic [STK_AW-1:0] stk_waddr, stk_raddr;
   logic [6:0]        stk_wdata;

   state_type         state_ff, state_in;
   logic [TBL_AW-1:0] clr_ff, clr_in;
   logic [SP_W-1:0]   sp_ff, sp_in;
   logic              active_ff, active_in;
   logic [6:0]        n_ff, n_in;
   logic [3:0]        cnt_ff, cnt_in;
   logic [6:0]        p_ff, p_in;
   logic [6:0]        tok_ff, tok_in;
   act_type           em_act_ff, em_act_in;
   logic [6:0]        em_prod_ff, em_prod_in;
   logic              em_last_ff, em_last_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic              out_free;
   logic [1:0]        st;
   logic [3:0]        l;
   logic [SP_W+1:0]   need;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign busy      = (state_ff == S_CLEAR);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign st   = tbl_rd_ff[8:7];
   assign l    = (len_rd_ff > 4'(RHS_MAX)) ? 4'(RHS_MAX) : len_rd_ff;
   // depth after expansion, plus one
   assign need = (SP_W+2)'(sp_ff) + (SP_W+2)'(l);

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      sp_in        = sp_ff;
      active_in    = active_ff;
      n_in         = n_ff;
      cnt_in       = cnt_ff;
      p_in         = p_ff;
      tok_in       = tok_ff;
      em_act_in    = em_act_ff;
      em_prod_in   = em_prod_ff;
      em_last_in   = em_last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      q_pop        = 1'b0;

      tbl_we    = 1'b0;
      tbl_waddr = TBL_AW'(q_head.req.cell_nonterminal * COLUMNS
                          + q_head.req.cell_terminal);
      tbl_wdata = {q_head.req.cell_status, q_head.req.production};
      tbl_raddr = TBL_AW'(stk_rd_ff[5:0] * COLUMNS + tok_ff);
      sym_we    = 1'b0;
      sym_waddr = RHS_AW'(q_head.req.production * RHS_MAX + q_head.req.rhs_position);
      sym_raddr = RHS_AW'(p_ff * RHS_MAX + (cnt_ff - 4'd1));
      len_raddr = PROD_AW'(tbl_rd_ff[6:0]);
      stk_we    = 1'b0;
      stk_waddr = sp_ff[STK_AW-1:0];
      stk_wdata = sym_rd_ff;
      stk_raddr = STK_AW'(sp_ff - 1'b1);

      case (state_ff)
         S_CLEAR: begin
            tbl_we    = 1'b1;
            tbl_waddr = clr_ff;
            tbl_wdata = '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == TBL_AW'(TBL_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               case (q_head.kind)
                  OP_TABLE: tbl_we = q_head.ok;
                  OP_RHS:   sym_we = q_head.ok;
                  OP_TOKEN: begin
                     tok_in = q_head.req.token;
                     n_in   = '0;
                     if (!active_ff) begin
                        stk_we    = 1'b1;
                        stk_waddr = '0;
                        stk_wdata = {1'b1, start_nt};
                        sp_in     = SP_W'(1);
                        active_in = 1'b1;
                     end
                     if (!q_head.ok) begin
                        em_act_in  = ACT_INVALID;
                        em_prod_in = '0;
                        em_last_in = 1'b1;
                        active_in  = 1'b0;
                        state_in   = S_EMIT;
                     end else begin
                        state_in = S_TOP;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_TOP: begin
            if (sp_ff == '0 || sp_ff > SP_W'(STACK_DEPTH)) begin
               em_act_in  = (tok_ff == 7'(TERMINALS)) ? ACT_ACCEPT : ACT_MISMATCH;
               em_prod_in = '0;
               em_last_in = 1'b1;
               active_in  = 1'b0;
               state_in   = S_EMIT;
            end else begin
               state_in = S_TOPW;
            end
         end
         S_TOPW: begin
            em_prod_in = '0;
            em_last_in = 1'b1;
            if (!stk_rd_ff[6]) begin
               if (tok_ff != 7'(TERMINALS) && stk_rd_ff == tok_ff) begin
                  em_act_in = ACT_MATCH;
                  sp_in     = sp_ff - 1'b1;
               end else begin
                  em_act_in = ACT_MISMATCH;
                  active_in = 1'b0;
               end
               state_in = S_EMIT;
            end else if ({1'b0, stk_rd_ff[5:0]} >= 7'(NONTERMINALS)) begin
               em_act_in = ACT_NO_ENTRY;
               active_in = 1'b0;
               state_in  = S_EMIT;
            end else begin
               state_in = S_CELL;
            end
         end
         S_CELL: begin
            p_in       = tbl_rd_ff[6:0];
            em_prod_in = '0;
            em_last_in = 1'b1;
            if (st == 2'd0 || (st == 2'd1 && {1'b0, tbl_rd_ff[6:0]} >= 8'(PRODUCTIONS))) begin
               em_act_in = ACT_NO_ENTRY;
               active_in = 1'b0;
               state_in  = S_EMIT;
            end else if (st[1]) begin
               em_act_in = ACT_AMBIGUOUS;
               active_in = 1'b0;
               state_in  = S_EMIT;
            end else begin
               state_in = S_LEN;
            end
         end
         S_LEN: begin
            if (n_ff >= 7'(MAX_RESULTS - 1) || need > (SP_W+2)'(STACK_DEPTH + 1)) begin
               em_act_in  = ACT_OVERFLOW;
               em_prod_in = '0;
               em_last_in = 1'b1;
               active_in  = 1'b0;
               state_in   = S_EMIT;
            end else begin
               sp_in      = sp_ff - 1'b1;
               cnt_in     = l;
               em_act_in  = ACT_EXPAND;
               em_prod_in = p_ff;
               em_last_in = 1'b0;
               state_in   = (l == 4'd0) ? S_EMIT : S_PUSHR;
            end
         end
         S_PUSHR: begin
            state_in = S_PUSHW;
         end
         S_PUSHW: begin
            stk_we   = 1'b1;
            sp_in    = sp_ff + 1'b1;
            cnt_in   = cnt_ff - 1'b1;
            state_in = (cnt_ff == 4'd1) ? S_EMIT : S_PUSHR;
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in                   = 1'b1;
               rsp_data_in.action             = em_act_ff;
               rsp_data_in.applied_production = em_prod_ff;
               rsp_data_in.last               = em_last_ff;
               n_in                           = n_ff + 1'b1;
               state_in                       = em_last_ff ? S_IDLE : S_TOP;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         sp_ff        <= '0;
         active_ff    <= 1'b0;
         n_ff         <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         sp_ff        <= sp_in;
         active_ff    <= active_in;
         n_ff         <= n_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff        <= p_in;
      tok_ff      <= tok_in;
      em_act_ff   <= em_act_in;
      em_prod_ff  <= em_prod_in;
      em_last_ff  <= em_last_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         tbl_mem[tbl_waddr] <= tbl_wdata;
      end
      tbl_rd_ff <= tbl_mem[tbl_raddr];
   end

   always_ff @(posedge clock) begin
      if (sym_we) begin
         sym_mem[sym_waddr] <= q_head.req.rhs_symbol;
      end
      sym_rd_ff <= sym_mem[sym_raddr];
   end

   always_ff @(posedge clock) begin
      if (sym_we) begin
         len_mem[PROD_AW'(q_head.req.production)] <= q_head.req.rhs_length;
      end
      len_rd_ff <= len_mem[len_raddr];
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[stk_waddr] <= stk_wdata;
      end
      stk_rd_ff <= stk_mem[stk_raddr];
   end

endmodule

// File: src/ll1_predictive_parse_engine_unit.sv
// ----------------------------------------------------------------------------
// ll1_predictive_parse_engine_unit
// Table-driven LL(1) parse engine: table/RHS loads and token parsing.
//
//   channel  direction  handshake          payload
//   req_     in         req_valid/stall    lpp_pkg::req_type
//   rsp_     out        rsp_valid/stall    lpp_pkg::rsp_type
//   csr_     in         csr_wr_en          csr_index, csr_wr_data
//
// Loads are written as the sequencer pops them in S_IDLE. A token starts in
// S_IDLE; each step then runs match: S_TOP, S_TOPW, S_EMIT; accept: S_TOP,
// S_EMIT; expand: S_TOP, S_TOPW, S_CELL, S_LEN, S_PUSHR/S_PUSHW per pushed
// symbol, S_EMIT; an invalid token goes from S_IDLE to S_EMIT. After reset
// the table is cleared, one cell a cycle (NONTERMINALS*(TERMINALS+1) cells,
// 4160 at defaults); requests stall meanwhile. A two-entry queue keeps req_
// open while the sequencer waits on a stalled rsp_.
// ----------------------------------------------------------------------------
module ll1_predictive_parse_engine_unit #(
   parameter int TERMINALS    = lpp_pkg::TERMINALS_DEF,
   parameter int NONTERMINALS = lpp_pkg::NONTERMINALS_DEF,
   parameter int PRODUCTIONS  = lpp_pkg::PRODUCTIONS_DEF,
   parameter int RHS_MAX      = lpp_pkg::RHS_MAX_DEF,
   parameter int STACK_DEPTH  = lpp_pkg::STACK_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  lpp_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output lpp_pkg::rsp_type                    rsp_data,
   input  logic                                csr_wr_en,
   input  logic [lpp_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [lpp_pkg::CSR_DATA_W-1:0]      csr_wr_data
);
   import lpp_pkg::*;

   logic [5:0] start_nt_ff;
   logic [6:0] num_terminals_ff;
   logic       q_valid, q_pop, busy;
   entry_type  q_head;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_nt_ff      <= '0;
         num_terminals_ff <= 7'd64;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_START_SYMBOL:  start_nt_ff      <= csr_wr_data[5:0];
            CSR_NUM_TERMINALS: num_terminals_ff <= csr_wr_data[6:0];
            default: ;
         endcase
      end
   end

   lpp_front #(
      .TERMINALS    (TERMINALS),
      .NONTERMINALS (NONTERMINALS),
      .PRODUCTIONS  (PRODUCTIONS),
      .RHS_MAX      (RHS_MAX)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .num_terminals (num_terminals_ff),
      .busy          (busy),
      .q_valid       (q_valid),
      .q_head        (q_head),
      .q_pop         (q_pop)
   );

   lpp_engine #(
      .TERMINALS    (TERMINALS),
      .NONTERMINALS (NONTERMINALS),
      .PRODUCTIONS  (PRODUCTIONS),
      .RHS_MAX      (RHS_MAX),
      .STACK_DEPTH  (STACK_DEPTH)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_head       (q_head),
      .q_pop        (q_pop),
      .busy         (busy),
      .start_nt     (start_nt_ff),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data)
   );

endmodule
